@@ rtl/atsc_pkg.sv @@
// ============================================================================
// atsc_pkg
// Shared types and constants for the adaptive threshold step counter.
// ============================================================================
`default_nettype none

package atsc_pkg;

   // Field widths of the input and result items.
   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int MAG_W      = 17;
   localparam int PEAK_W     = 25;
   localparam int FRAC_BITS  = 8;

   // Square root datapath sizes: the radicand is the sum of three squares.
   localparam int SUM_W      = 32;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int ITER_W     = $clog2(ROOT_STEPS);

   // Peak tracker gains, as right shifts.
   localparam int SHIFT_FAST = 1;
   localparam int SHIFT_SLOW = 4;

   // Reset value of the lockout register.
   localparam logic [TIME_W-1:0] LOCKOUT_RESET = TIME_W'(300);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 3 * SAMPLE_W + TIME_W;
   localparam int RSP_BITS   = COUNT_W + MAG_W + PEAK_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Axis selected for the shared squaring multiplier.
   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } atsc_axis_type;

   // Step detection phase.
   typedef enum logic [1:0] {
      PH_WAIT,
      PH_ABOVE,
      PH_LOCK
   } atsc_phase_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_ACC,
      ST_ROOT,
      ST_UPDATE
   } atsc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          load;
      logic          mul_en;
      atsc_axis_type axis;
      logic          acc_en;
      logic          root_init;
      logic          root_step;
      logic          update;
   } atsc_cmd_type;

endpackage

`default_nettype wire

@@ rtl/atsc_ctrl.sv @@
// ============================================================================
// atsc_ctrl
// Sequencer for one item: three squarings, a bit-serial square root, then
// the tracker update into the result register.
// ============================================================================
`default_nettype none

module atsc_ctrl
   import atsc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      atsc_cmd_type cmd
);

   atsc_state_type           state_ff, state_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // State, iteration counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      cmd        = '0;
      cmd.axis   = AXIS_X;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.mul_en = 1'b1;
            cmd.axis   = AXIS_X;
            state_in   = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.mul_en = 1'b1;
            cmd.axis   = AXIS_Y;
            cmd.acc_en = 1'b1;
            state_in   = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            cmd.mul_en = 1'b1;
            cmd.axis   = AXIS_Z;
            cmd.acc_en = 1'b1;
            state_in   = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            cmd.root_init = 1'b1;
            iter_in       = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            iter_in       = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(ROOT_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Wait until the result register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result stays offered until it is taken.
   assign rsp_valid_in = cmd.update | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/atsc_datapath.sv @@
// ============================================================================
// atsc_datapath
// Squaring multiplier, sum, bit-serial square root, peak tracker, step
// phase machine and the result register.
// ============================================================================
`default_nettype none

module atsc_datapath
   import atsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire atsc_cmd_type          cmd,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [TIME_W-1:0]     csr_wr_data,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tuser
);

   // Captured item.
   logic signed [SAMPLE_W-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_W-1:0]          time_ff;

   // Squaring and sum.
   logic signed [SAMPLE_W-1:0]   mul_op;
   logic signed [2*SAMPLE_W-1:0] prod_in, prod_ff;
   logic [SUM_W-1:0]             sum_ff, sum_in;

   // Square root.
   logic [SUM_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff;

   // Tracker and step state.
   logic [TIME_W-1:0]  lockout_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   atsc_phase_type     phase_ff, phase_in;
   logic [TIME_W-1:0]  lock_start_ff, lock_start_in, elapsed;
   logic [PEAK_W-1:0]  peak_ff, new_peak;
   logic [MAG_W-1:0]   prev_ff, mag;
   logic               seen_in;

   // Tracker arithmetic.
   logic [PEAK_W-1:0]        mag_fx, prev_fx;
   logic                     gain_fast;
   logic signed [PEAK_W+1:0] diff, delta, np;
   logic [PEAK_W:0]          two_mag;
   logic                     above;

   // Result register.
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_seen_ff;
   logic [MAG_W-1:0]   out_mag_ff;
   logic [PEAK_W-1:0]  out_thr_ff;

   // Lockout configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RESET;
      end else if (csr_wr_en) begin
         lockout_ff <= csr_wr_data;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= req_tdata[SAMPLE_W-1:0];
         ay_ff   <= req_tdata[2*SAMPLE_W-1:SAMPLE_W];
         az_ff   <= req_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
         time_ff <= req_tdata[3*SAMPLE_W+TIME_W-1:3*SAMPLE_W];
      end
   end

   // Shared multiplier squares one axis per cycle.
   always_comb begin
      case (cmd.axis)
         AXIS_X:  mul_op = ax_ff;
         AXIS_Y:  mul_op = ay_ff;
         AXIS_Z:  mul_op = az_ff;
         default: mul_op = ax_ff;
      endcase
   end

   assign prod_in = mul_op * mul_op;
   assign sum_in  = sum_ff + SUM_W'($unsigned(prod_ff));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load) begin
         sum_ff <= '0;
      end else if (cmd.acc_en) begin
         sum_ff <= sum_in;
      end
   end

   // Square root, two radicand bits per step, one root bit per step.
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1:SUM_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rad_ff  <= sum_in;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Peak tracker: move toward the previous magnitude by 1/2 or 1/16.
   assign mag       = MAG_W'(root_ff);
   assign mag_fx    = PEAK_W'({mag, {FRAC_BITS{1'b0}}});
   assign prev_fx   = PEAK_W'({prev_ff, {FRAC_BITS{1'b0}}});
   assign gain_fast = mag_fx > peak_ff;
   assign diff      = $signed({2'b00, prev_fx}) - $signed({2'b00, peak_ff});
   assign delta     = gain_fast ? (diff >>> SHIFT_FAST) : (diff >>> SHIFT_SLOW);
   assign np        = $signed({2'b00, peak_ff}) + delta;

   always_comb begin
      if (np[PEAK_W+1]) begin
         new_peak = '0;
      end else if (np[PEAK_W]) begin
         new_peak = '1;
      end else begin
         new_peak = np[PEAK_W-1:0];
      end
   end

   // Twice the magnitude against the new peak is the threshold compare.
   assign two_mag = (PEAK_W+1)'({mag, {(FRAC_BITS+1){1'b0}}});
   assign above   = two_mag > {1'b0, new_peak};
   assign elapsed = time_ff - lock_start_ff;

   // Step phase machine.
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      lock_start_in = lock_start_ff;
      seen_in       = 1'b0;
      case (phase_ff)
         PH_WAIT: begin
            if (above) begin
               phase_in = PH_ABOVE;
            end
         end
         PH_ABOVE: begin
            if (!above) begin
               count_in      = count_ff + 1'b1;
               lock_start_in = time_ff;
               phase_in      = PH_LOCK;
               seen_in       = 1'b1;
            end
         end
         default: begin
            // Lockout ends once the elapsed time exceeds the setting.
            if (elapsed > lockout_ff) begin
               phase_in = PH_WAIT;
            end
         end
      endcase
   end

   // Tracker and step state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         count_ff      <= '0;
         lock_start_ff <= '0;
         peak_ff       <= '0;
         prev_ff       <= '0;
      end else if (cmd.update) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         lock_start_ff <= lock_start_in;
         peak_ff       <= new_peak;
         prev_ff       <= mag;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_count_ff <= count_in;
         out_seen_ff  <= seen_in;
         out_mag_ff   <= mag;
         out_thr_ff   <= new_peak >> 1;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({out_thr_ff, out_mag_ff, out_count_ff});
   assign rsp_tuser = out_seen_ff;

endmodule

`default_nettype wire

@@ rtl/adaptive_threshold_step_counter_unit.sv @@
// ============================================================================
// adaptive_threshold_step_counter_unit
// Step counter on accelerometer samples: magnitude by integer square root,
// adaptive peak threshold and a lockout after each counted step.
// ============================================================================
//
//  Port group   Direction  Contents
//  req_*        in         one sample item per handshake
//  rsp_*        out        one result item per sample
//  csr_*        in         lockout time register write
//
// An item's result is offered after three squarings on the shared multiplier,
// a sum step, sixteen square root steps (one root bit each) and one update.
// The next item is accepted in the cycle after the update, so items are taken
// one at a time and a new one is not taken before the last is through, while
// the previous result may still wait in the result register.
// If that result is still held when the next update is due, the sequencer
// waits for it to be taken. Reset is synchronous and sets the lockout time
// to 300 ms and clears the count, phase and peak.
// ============================================================================
`default_nettype none

module adaptive_threshold_step_counter_unit
   import atsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [63:48]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // step_total [15:0], magnitude [32:16], threshold [57:33], zeros above
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // step_seen [0]
   output      logic                  rsp_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_wr_en,
   input  wire logic [TIME_W-1:0]     csr_wr_data
);

   atsc_cmd_type cmd;

   // Sequencer.
   atsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Arithmetic and state.
   atsc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ sim/adaptive_threshold_step_counter_unit_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// adaptive_threshold_step_counter_unit_test
// Self-checking bench for the step counter. A queue of accelerometer samples
// feeds a clocked driver. Each accepted item updates a bit-accurate model of
// the magnitude, peak tracker and step machine, which queues the result it
// predicts. A clocked monitor compares every result item with the oldest
// prediction. Both sides stall at random. The lockout register is rewritten
// between phases, but only while the block is idle.
// ============================================================================

module adaptive_threshold_step_counter_unit_test;
   import atsc_pkg::*;

   // One accelerometer sample, as carried in req_tdata.
   typedef struct packed {
      logic [TIME_W-1:0]          time_ms;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_x;
   } sample_type;

   // One predicted result item.
   typedef struct packed {
      logic [COUNT_W-1:0] step_total;
      logic               step_seen;
      logic [MAG_W-1:0]   magnitude;
      logic [PEAK_W-1:0]  threshold;
   } step_result_type;

   localparam longint PEAK_CEILING = (64'd1 << PEAK_W) - 1;
   localparam int     SETTLE_CYCLES = 40;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [TIME_W-1:0]     csr_wr_data = '0;

   // Stimulus and prediction stores.
   sample_type      pending_samples[$];
   step_result_type awaited_results[$];
   sample_type      req_item;
   int              mismatch_count = 0;
   bit              no_stall       = 1'b0;

   // Model state of the step counter.
   logic [TIME_W-1:0]  model_lockout    = LOCKOUT_RESET;
   logic [COUNT_W-1:0] model_steps      = '0;
   atsc_phase_type     model_phase      = PH_WAIT;
   logic [TIME_W-1:0]  model_lock_start = '0;
   logic [PEAK_W-1:0]  model_peak       = '0;
   logic [MAG_W-1:0]   model_prev_mag   = '0;

   // Walking pattern state for the random part.
   logic [TIME_W-1:0] walk_ms   = '0;
   bit                walk_high = 1'b0;
   int                walk_run  = 0;

   adaptive_threshold_step_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock, 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floored square root, one result bit per pass.
   function automatic logic [MAG_W-1:0] floor_sqrt(input longint unsigned radicand);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest  = radicand;
      root  = 0;
      probe = 64'd1 << 34;
      while (probe > rest && probe != 0)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[MAG_W-1:0];
   endfunction

   // Advances the model by one sample and returns the result it causes.
   function automatic step_result_type track_sample(input sample_type s);
      step_result_type res;
      longint          sx;
      longint          sy;
      longint          sz;
      longint          mag;
      longint          diff;
      longint          nudge;
      longint          next_peak;
      logic [TIME_W-1:0] elapsed;
      sx  = longint'(s.accel_x);
      sy  = longint'(s.accel_y);
      sz  = longint'(s.accel_z);
      mag = longint'(floor_sqrt(sx * sx + sy * sy + sz * sz));

      // Fast gain while the new magnitude lies above the old peak.
      diff = (longint'(model_prev_mag) <<< FRAC_BITS) - longint'(model_peak);
      if ((mag <<< FRAC_BITS) > longint'(model_peak))
         nudge = diff >>> SHIFT_FAST;
      else
         nudge = diff >>> SHIFT_SLOW;
      next_peak = longint'(model_peak) + nudge;
      if (next_peak < 0)
         next_peak = 0;
      if (next_peak > PEAK_CEILING)
         next_peak = PEAK_CEILING;
      model_peak     = next_peak[PEAK_W-1:0];
      model_prev_mag = mag[MAG_W-1:0];

      res.step_seen = 1'b0;
      case (model_phase)
         PH_WAIT: begin
            if ((mag <<< (FRAC_BITS + 1)) > next_peak)
               model_phase = PH_ABOVE;
         end
         PH_ABOVE: begin
            if ((mag <<< (FRAC_BITS + 1)) <= next_peak) begin
               model_steps      = model_steps + 1'b1;
               model_lock_start = s.time_ms;
               model_phase      = PH_LOCK;
               res.step_seen    = 1'b1;
            end
         end
         default: begin
            // Lockout, and the unused fourth phase with it.
            elapsed = s.time_ms - model_lock_start;
            if (elapsed > model_lockout)
               model_phase = PH_WAIT;
         end
      endcase

      res.step_total = model_steps;
      res.magnitude  = mag[MAG_W-1:0];
      res.threshold  = model_peak >> 1;
      return res;
   endfunction

   task automatic queue_sample(input int ax, input int ay, input int az, input int t);
      sample_type s;
      s.accel_x = ax[SAMPLE_W-1:0];
      s.accel_y = ay[SAMPLE_W-1:0];
      s.accel_z = az[SAMPLE_W-1:0];
      s.time_ms = t[TIME_W-1:0];
      pending_samples.push_back(s);
   endtask

   // Mostly walking patterns, with noise and corner values in between.
   task automatic queue_random(input int count);
      int pick;
      int amp;
      int axis;
      int v[3];
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if ($urandom_range(19) == 0)
            walk_ms = TIME_W'($urandom);
         else
            walk_ms = walk_ms + TIME_W'($urandom_range(60));
         if (pick < 65) begin
            if (walk_run == 0) begin
               walk_high = ~walk_high;
               walk_run  = $urandom_range(4, 1);
            end
            walk_run = walk_run - 1;
            amp  = walk_high ? $urandom_range(32767, 12000) : $urandom_range(3000);
            axis = $urandom_range(2);
            for (int a = 0; a < 3; a++)
               v[a] = $urandom_range(1000) - 500;
            v[axis] = $urandom_range(1) ? -amp : amp;
            queue_sample(v[0], v[1], v[2], walk_ms);
         end else if (pick < 90) begin
            queue_sample($urandom, $urandom, $urandom,
                         $urandom_range(2) == 0 ? $urandom : walk_ms);
         end else begin
            for (int a = 0; a < 3; a++) begin
               case ($urandom_range(3))
                  0: v[a] = -32768;
                  1: v[a] = 32767;
                  2: v[a] = 0;
                  default: v[a] = -1;
               endcase
            end
            queue_sample(v[0], v[1], v[2], walk_ms);
         end
      end
   endtask

   // Waits until every sample is sent and answered, then lets the block settle.
   task automatic settle_block;
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the lockout register while the block is idle.
   task automatic set_lockout(input logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      model_lockout = value;
   endtask

   // Driver: offers the next sample once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(track_sample(req_item));
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && (no_stall || $urandom_range(99) >= 10)) begin
               req_item = pending_samples.pop_front();
               req_tdata  <= req_item;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result item against the oldest prediction.
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected result item: tdata %h tuser %b", rsp_tdata, rsp_tuser);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tdata[COUNT_W-1:0] !== want.step_total ||
                rsp_tuser !== want.step_seen ||
                rsp_tdata[COUNT_W+MAG_W-1:COUNT_W] !== want.magnitude ||
                rsp_tdata[RSP_BITS-1:COUNT_W+MAG_W] !== want.threshold) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("mismatch: steps %0d/%0d seen %b/%b mag %0d/%0d thr %0d/%0d",
                           want.step_total, rsp_tdata[COUNT_W-1:0],
                           want.step_seen, rsp_tuser,
                           want.magnitude, rsp_tdata[COUNT_W+MAG_W-1:COUNT_W],
                           want.threshold, rsp_tdata[RSP_BITS-1:COUNT_W+MAG_W]);
            end
         end
      end
      rsp_tready <= no_stall || ($urandom_range(99) >= 10);
   end

   // Run watchdog.
   initial begin
      #4000000;
      $display("adaptive_threshold_step_counter_unit_test failed");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset lockout of 300 ms.
      queue_sample(0, 0, 0, 0);
      queue_sample(-32768, -32768, -32768, 10);
      queue_sample(32767, 32767, 32767, 20);
      queue_sample(0, 0, 0, 30);
      queue_sample(-32768, 0, 0, 100);
      queue_sample(0, 0, 0, 330);
      queue_sample(0, 0, 0, 331);
      queue_sample(1, -1, 1, 340);
      queue_sample(32767, 0, -32768, 350);
      queue_sample(0, 0, 0, 360);
      queue_sample(0, 0, 0, 660);
      queue_sample(0, 0, 0, 661);
      // Lockout across the wrap of the millisecond tick.
      queue_sample(-32768, 32767, 0, 65400);
      queue_sample(0, 0, 0, 65450);
      queue_sample(12, -7, 3, 100);
      queue_sample(0, 0, 0, 214);
      queue_sample(0, 0, 0, 215);
      // Peak decay toward a small magnitude, rounded towards minus infinity.
      queue_sample(-1, 0, 0, 300);
      queue_sample(0, -1, 0, 310);
      queue_sample(0, 0, 32767, 320);
      queue_sample(0, 0, -32768, 330);
      queue_sample(3, 4, 12, 65535);
      settle_block();

      set_lockout('0);
      queue_random(110);
      settle_block();

      set_lockout('1);
      queue_random(60);
      settle_block();

      // A stretch with no stalls on either side.
      set_lockout(TIME_W'(1));
      no_stall = 1'b1;
      queue_random(120);
      settle_block();
      no_stall = 1'b0;

      set_lockout(TIME_W'($urandom));
      queue_random(130);
      settle_block();

      set_lockout(TIME_W'($urandom_range(400, 50)));
      queue_random(130);
      settle_block();

      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("adaptive_threshold_step_counter_unit_test passed");
      else
         $display("adaptive_threshold_step_counter_unit_test failed");
      $finish;
   end

endmodule
